### src/rth_pkg.sv
// ----------------------------------------------------------------------------
// rth_pkg
// shared widths, constants, stage payload types and the arctangent table
// ----------------------------------------------------------------------------
`default_nettype none

package rth_pkg;

    localparam int XW    = 43;   // cordic x / y, signed q30
    localparam int ZW    = 33;   // cordic angle accumulator, signed q30
    localparam int SW    = 19;   // saturation dividend / remainder
    localparam int DW    = 11;   // saturation divisor (2 * sum)
    localparam int HW    = 42;   // hue dividend / remainder
    localparam int QW    = 8;    // quotient bits of both dividers
    localparam int STEPS = 28;   // cordic iterations

    localparam logic [31:0] SQRT3_Q30   = 32'd1859775393;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;

    localparam logic [9:0]  SAT_GAIN    = 10'd511;
    localparam logic [10:0] SAT_MIN_K   = 11'd1530;
    localparam logic [7:0]  HUE_SCALE   = 8'd255;
    localparam logic [11:0] INT_RECIP   = 12'd2731;   // 2^14 / 6, rounded up
    localparam int          INT_SHIFT   = 14;

    typedef struct packed {
        logic grey;
        logic dzero;
        logic numneg;
        logic bgtg;
    } rth_flags_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [SW-1:0]        rem;
        logic [DW-1:0]        den;
        logic [QW-1:0]        q;
        rth_flags_t           flags;
        logic [7:0]           inten;
    } rth_cord_t;

    typedef struct packed {
        logic [HW-1:0] rem;
        logic [QW-1:0] q;
        logic [7:0]    sat;
        logic [7:0]    inten;
    } rth_hdiv_t;

    function automatic logic [ZW-1:0] atan_q30(input logic [4:0] i);
        logic [ZW-1:0] v;
        unique case (i)
            5'd0:    v = ZW'(843314857);
            5'd1:    v = ZW'(497837829);
            5'd2:    v = ZW'(263043837);
            5'd3:    v = ZW'(133525159);
            5'd4:    v = ZW'(67021687);
            5'd5:    v = ZW'(33543516);
            5'd6:    v = ZW'(16775851);
            5'd7:    v = ZW'(8388437);
            5'd8:    v = ZW'(4194283);
            5'd9:    v = ZW'(2097149);
            5'd10:   v = ZW'(1048576);
            5'd11:   v = ZW'(524288);
            5'd12:   v = ZW'(262144);
            5'd13:   v = ZW'(131072);
            5'd14:   v = ZW'(65536);
            5'd15:   v = ZW'(32768);
            5'd16:   v = ZW'(16384);
            5'd17:   v = ZW'(8192);
            5'd18:   v = ZW'(4096);
            5'd19:   v = ZW'(2048);
            5'd20:   v = ZW'(1024);
            5'd21:   v = ZW'(512);
            5'd22:   v = ZW'(256);
            5'd23:   v = ZW'(128);
            5'd24:   v = ZW'(64);
            5'd25:   v = ZW'(32);
            5'd26:   v = ZW'(16);
            5'd27:   v = ZW'(8);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### src/rgb_to_hsi_pixel.sv
// ----------------------------------------------------------------------------
// rgb_to_hsi_pixel
// 8-bit rgb pixel to 8-bit hue, saturation and intensity, fully pipelined
// ----------------------------------------------------------------------------
//
//  channel   signals                          direction
//  -------   ------------------------------   ---------
//  input     in_valid, in_stall, red/green/blue   pixel in
//  output    out_valid, out_stall, hue/saturation/intensity   result out
//
//  one pixel accepted per clock while in_stall is low; stages are the prep stage, 28 cordic
//  cells, two hue scaling stages, 8 hue divide cells and the output register
//  the pipeline advances as a whole while the skid register is empty
//  a stalled output parks the next result in the skid register; in_stall is
//  the skid-full flag, so input stalls only in the cycle after a stalled output meets a new result
//  rst_n clears the valid bits and the skid flag only
//
`default_nettype none

module rgb_to_hsi_pixel
    import rth_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] hue,
    output logic [7:0] saturation,
    output logic [7:0] intensity
);

    localparam int NST = 1 + STEPS + 2 + QW;   // pipeline stages before the output

    logic           en;
    logic [NST-1:0] vld_reg;

    // prep stage: channel arithmetic and cordic start vector
    rth_cord_t            c_bus [0:STEPS];
    rth_cord_t            prep_next;
    logic [9:0]           sum;
    logic [7:0]           mn;
    logic signed [10:0]   num_s;
    logic [10:0]          num_abs;
    logic signed [8:0]    d_s;
    logic [8:0]           d_abs;
    logic [39:0]          y_prod;
    logic [22:0]          int_prod;

    always_comb
    begin
        sum      = 10'(red) + 10'(green) + 10'(blue);
        mn       = (red < green) ? red : green;
        mn       = (blue < mn) ? blue : mn;
        num_s    = $signed({2'b0, red, 1'b0}) - $signed({3'b0, green})
                 - $signed({3'b0, blue});
        num_abs  = num_s[10] ? 11'(-num_s) : 11'(num_s);
        d_s      = $signed({1'b0, green}) - $signed({1'b0, blue});
        d_abs    = d_s[8] ? 9'(-d_s) : 9'(d_s);
        y_prod   = 40'(d_abs[7:0]) * 40'(SQRT3_Q30);
        int_prod = 23'({sum, 1'b0} + 11'd3) * 23'(INT_RECIP);

        prep_next.x            = $signed(XW'({num_abs[8:0], 30'b0}));
        prep_next.y            = $signed(XW'(y_prod));
        prep_next.z            = '0;
        prep_next.rem          = SW'(sum) * SW'(SAT_GAIN) - SW'(mn) * SW'(SAT_MIN_K);
        prep_next.den          = {sum, 1'b0};
        prep_next.q            = '0;
        prep_next.flags.grey   = (red == green) && (green == blue);
        prep_next.flags.dzero  = (green == blue);
        prep_next.flags.numneg = num_s[10];
        prep_next.flags.bgtg   = (blue > green);
        prep_next.inten        = int_prod[INT_SHIFT+7:INT_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_bus[0] <= prep_next;
        end
    end

    // cordic chain, the first cells also run the saturation divide
    for (genvar k = 0; k < STEPS; k++)
    begin : g_cordic
        rth_cordic_cell u_cell (
            .clk   (clk),
            .adv   (en),
            .step  (5'(k)),
            .d_in  (c_bus[k]),
            .d_out (c_bus[k+1])
        );
    end

    // scale stage 1: clamp the angle, fold into the full circle
    rth_cord_t            cend;
    logic [30:0]          phi;
    logic [31:0]          theta;
    logic [32:0]          full_next;
    logic [32:0]          full_reg;
    logic                 grey_reg;
    logic [7:0]           sat_reg;
    logic [7:0]           inten1_reg;

    always_comb
    begin
        cend = c_bus[STEPS];
        if (cend.z[ZW-1])
        begin
            phi = '0;
        end
        else if (cend.z > $signed(ZW'(HALF_PI_Q30)))
        begin
            phi = HALF_PI_Q30;
        end
        else
        begin
            phi = cend.z[30:0];
        end
        if (cend.flags.dzero)
        begin
            theta = cend.flags.numneg ? PI_Q30 : '0;
        end
        else
        begin
            theta = cend.flags.numneg ? (PI_Q30 - 32'(phi)) : 32'(phi);
        end
        full_next = cend.flags.bgtg ? (TWO_PI_Q30 - 33'(theta)) : 33'(theta);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            full_reg   <= full_next;
            grey_reg   <= cend.flags.grey;
            sat_reg    <= cend.flags.grey ? 8'd0 : cend.q;
            inten1_reg <= cend.inten;
        end
    end

    // scale stage 2: angle * 255 plus half a divisor for rounding
    rth_hdiv_t h_bus [0:QW];
    rth_hdiv_t h_next;

    always_comb
    begin
        h_next.rem   = grey_reg ? '0
                     : HW'(full_reg) * HW'(HUE_SCALE) + HW'(PI_Q30);
        h_next.q     = '0;
        h_next.sat   = sat_reg;
        h_next.inten = inten1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_bus[0] <= h_next;
        end
    end

    // divide by two pi, one quotient bit per cell
    for (genvar k = 0; k < QW; k++)
    begin : g_hdiv
        rth_hue_div_cell u_cell (
            .clk   (clk),
            .adv   (en),
            .step  (3'(k)),
            .d_in  (h_bus[k]),
            .d_out (h_bus[k+1])
        );
    end

    // valid bits follow the data through every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    // output register with a skid register behind it
    logic      ov_reg;
    logic      sv_reg;
    rth_hdiv_t out_reg;
    rth_hdiv_t skid_reg;
    logic      pv;

    assign pv = vld_reg[NST-1] && en;
    assign en = !sv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else if (!ov_reg || !out_stall)
        begin
            ov_reg <= sv_reg || pv;
            sv_reg <= 1'b0;
        end
        else if (pv)
        begin
            sv_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ov_reg || !out_stall)
        begin
            out_reg <= sv_reg ? skid_reg : h_bus[QW];
        end
        else if (pv)
        begin
            skid_reg <= h_bus[QW];
        end
    end

    assign in_stall   = sv_reg;
    assign out_valid  = ov_reg;
    assign hue        = out_reg.q;
    assign saturation = out_reg.sat;
    assign intensity  = out_reg.inten;

endmodule

`default_nettype wire

### src/rth_cordic_cell.sv
// ----------------------------------------------------------------------------
// rth_cordic_cell
// one vectoring cordic iteration plus, in the first QW cells, one saturation divide step
// ----------------------------------------------------------------------------
`default_nettype none

module rth_cordic_cell
    import rth_pkg::*;
(
    input  logic      clk,
    input  logic      adv,
    input  logic [4:0] step,
    input  rth_cord_t d_in,
    output rth_cord_t d_out
);

    rth_cord_t d_reg;
    rth_cord_t d_next;

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic [ZW-1:0]        a;
    logic [2:0]           sh;
    logic [SW-1:0]        trial;
    logic                 div_en;

    always_comb
    begin
        d_next = d_in;
        dx     = d_in.y >>> step;
        dy     = d_in.x >>> step;
        a      = atan_q30(step);
        if (!d_in.y[XW-1])
        begin
            d_next.x = d_in.x + dx;
            d_next.y = d_in.y - dy;
            d_next.z = d_in.z + $signed(a);
        end
        else
        begin
            d_next.x = d_in.x - dx;
            d_next.y = d_in.y + dy;
            d_next.z = d_in.z - $signed(a);
        end
        // restoring divide, msb first, in the first cells only
        div_en = (step < 5'(QW));
        sh     = 3'(5'(QW - 1) - step);
        trial  = SW'(d_in.den) << sh;
        if (div_en)
        begin
            if (d_in.rem >= trial)
            begin
                d_next.rem = d_in.rem - trial;
                d_next.q   = {d_in.q[QW-2:0], 1'b1};
            end
            else
            begin
                d_next.q   = {d_in.q[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

`default_nettype wire

### src/rth_hue_div_cell.sv
// ----------------------------------------------------------------------------
// rth_hue_div_cell
// one restoring step of the hue divide by two pi in q30
// ----------------------------------------------------------------------------
`default_nettype none

module rth_hue_div_cell
    import rth_pkg::*;
(
    input  logic      clk,
    input  logic      adv,
    input  logic [2:0] step,
    input  rth_hdiv_t d_in,
    output rth_hdiv_t d_out
);

    rth_hdiv_t     d_reg;
    rth_hdiv_t     d_next;
    logic [2:0]    sh;
    logic [HW-1:0] trial;

    always_comb
    begin
        d_next = d_in;
        sh     = 3'(QW - 1) - step;
        trial  = HW'(TWO_PI_Q30) << sh;
        if (d_in.rem >= trial)
        begin
            d_next.rem = d_in.rem - trial;
            d_next.q   = {d_in.q[QW-2:0], 1'b1};
        end
        else
        begin
            d_next.q   = {d_in.q[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

`default_nettype wire

### src/rth_checker.sv
// ----------------------------------------------------------------------------
// rth_checker
// port-level checks on the pixel converter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module rth_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] hue,
    input logic [7:0] saturation,
    input logic [7:0] intensity
);

    // no result shown while in reset
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("out_valid high in reset");

    // stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped under stall");

    // stalled result payload does not move
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(hue) && $stable(saturation)
                                   && $stable(intensity))
        else $error("result changed under stall");

    // input only stalls while a result is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

    // input stall starts only after a stalled transfer
    a_stall_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stall without output stall");

endmodule

bind rgb_to_hsi_pixel rth_checker u_rth_checker (.*);

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// rgb_to_hsi_pixel testbench
// drives random and corner-case rgb pixels through the converter, predicts
// hue, saturation and intensity with a fixed-point cordic model and checks
// every output transfer in order
// ----------------------------------------------------------------------------

class hsi_scoreboard;
    logic [23:0] pending_hsi[$];
    int          mismatches;

    // arithmetic shift right, floor rounding
    static function longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    static function longint quadrant_angle(longint x, longint y);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < rth_pkg::STEPS; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                z += longint'(rth_pkg::atan_q30(5'(i)));
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= longint'(rth_pkg::atan_q30(5'(i)));
            end
        end
        if (z < 0)
            z = 0;
        if (z > longint'(rth_pkg::HALF_PI_Q30))
            z = longint'(rth_pkg::HALF_PI_Q30);
        return z;
    endfunction

    static function logic [23:0] convert_pixel(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
        longint r, g, b, sum, mn, num, d, theta, full, hue, sat, inten, ax, ad;
        r = r8;
        g = g8;
        b = b8;
        sum = r + g + b;
        hue = 0;
        sat = 0;
        inten = (2 * sum + 3) / 6;
        if (!(r == g && g == b))
        begin
            mn = (r < g) ? r : g;
            if (b < mn)
                mn = b;
            sat = (511 * sum - 1530 * mn) / (2 * sum);
            if (sat > 255)
                sat = 255;
            num = 2 * r - g - b;
            d = g - b;
            if (d == 0)
                theta = (num > 0) ? 0 : longint'(rth_pkg::PI_Q30);
            else
            begin
                ax = (num < 0) ? -num : num;
                ad = (d < 0) ? -d : d;
                theta = quadrant_angle(ax <<< 30, ad * longint'(rth_pkg::SQRT3_Q30));
                if (num < 0)
                    theta = longint'(rth_pkg::PI_Q30) - theta;
            end
            full = (b > g) ? longint'(rth_pkg::TWO_PI_Q30) - theta : theta;
            hue = (full * 255 + longint'(rth_pkg::PI_Q30)) / longint'(rth_pkg::TWO_PI_Q30);
            if (hue > 255)
                hue = 255;
        end
        return {hue[7:0], sat[7:0], inten[7:0]};
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pending_hsi.push_back(convert_pixel(r, g, b));
    endfunction

    function void check_result(logic [7:0] h, logic [7:0] s, logic [7:0] i);
        logic [23:0] want;
        if (pending_hsi.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result h=%0d s=%0d i=%0d", h, s, i);
            return;
        end
        want = pending_hsi.pop_front();
        if (want !== {h, s, i})
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected h=%0d s=%0d i=%0d, got h=%0d s=%0d i=%0d",
                         want[23:16], want[15:8], want[7:0], h, s, i);
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rth_pkg::*;

    localparam int PIPE_LATENCY = 40;
    localparam int CYCLE_LIMIT  = 400000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] intensity;

    hsi_scoreboard hsi_board;

    // idle percentages, changed per phase by the stimulus process
    int  send_idle_pct;
    int  recv_idle_pct;
    // when set, the receiver holds off for a long stretch
    bit  hold_request;
    int  cycle_count;

    rgb_to_hsi_pixel DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hue        (hue),
        .saturation (saturation),
        .intensity  (intensity)
    );

    // 20 ns clock
    initial
        clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // present one pixel and hold it until the transfer happens
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        red      <= r;
        green    <= g;
        blue     <= b;
        // transfer occurs on a rising edge with stall low
        do
            @(posedge clk);
        while (in_stall);
        hsi_board.note_pixel(r, g, b);
        @(negedge clk);
    endtask

    // random pixel, biased toward greys, near-greys and green equal to blue
    task automatic send_random_pixel();
        logic [7:0] r, g, b;
        int kind;
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        kind = $urandom_range(9);
        if (kind == 0)
        begin
            g = r;
            b = r;
        end
        else if (kind == 1)
            b = g;
        else if (kind == 2)
        begin
            g = r + 8'($urandom_range(2));
            b = r - 8'($urandom_range(2));
        end
        send_pixel(r, g, b);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (hsi_board.pending_hsi.size() != 0)
            @(negedge clk);
    endtask

    // receiver: random stalls plus an occasional long hold-off
    initial
    begin
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                for (int n = 0; n < 3 * PIPE_LATENCY; n++)
                    @(negedge clk);
                hold_request = 1'b0;
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // output monitor
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            hsi_board.check_result(hue, saturation, intensity);

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        hsi_board     = new();
        cycle_count   = 0;
        hold_request  = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        red           = 8'd0;
        green         = 8'd0;
        blue          = 8'd0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed corners: greys, primaries, green equal blue both ways,
        // every bit set and clear on each channel
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd200, 8'd50,  8'd50);
        send_pixel(8'd10,  8'd90,  8'd90);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd1,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd254, 8'd255, 8'd255);
        send_pixel(8'd170, 8'd85,  8'd0);
        send_pixel(8'd85,  8'd170, 8'd255);
        send_pixel(8'd0,   8'd1,   8'd2);
        send_pixel(8'd2,   8'd1,   8'd0);
        send_pixel(8'd100, 8'd99,  8'd101);

        // sender pauses until everything has come back
        wait_drained();

        // long receiver hold-off while the sender keeps going, fills the pipe
        hold_request = 1'b1;
        for (int n = 0; n < 100; n++)
            send_random_pixel();

        send_idle_pct = 20;
        recv_idle_pct = 48;
        for (int n = 0; n < 600; n++)
            send_random_pixel();

        send_idle_pct = 48;
        recv_idle_pct = 20;
        for (int n = 0; n < 600; n++)
            send_random_pixel();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int n = 0; n < 630; n++)
            send_random_pixel();

        wait_drained();
        repeat (PIPE_LATENCY + 10)
            @(negedge clk);

        if (hsi_board.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
